// ===== sv/clr_pkg.sv =====
// Shared constants, codes and structs of the clipped line rasterizer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package clr_pkg;

   // Coordinate width and the largest visible screen dimension.
   localparam int COORD_BITS    = 16;
   localparam int MAX_DIM       = 4096;

   // Fixed field and register widths.
   localparam int SCREEN_BITS   = 13;
   localparam int PITCH_BITS    = 16;
   localparam int SCISSOR_BITS  = 16;
   localparam int COLOR_BITS    = 32;
   localparam int ADDR_BITS     = 26;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // Derived widths.
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int ERR_BITS      = COORD_BITS + 2;
   localparam int POS_BITS      = $clog2(MAX_DIM);
   localparam int DIM_BITS      = (POS_BITS + 1 > SCREEN_BITS) ? POS_BITS + 1 : SCREEN_BITS;
   localparam int STRIDE_BITS   = PITCH_BITS - 2;
   localparam int CLIP_BITS     = ((COORD_BITS > SCISSOR_BITS) ? COORD_BITS : SCISSOR_BITS) + 2;

   // Operation codes of an input word.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_PITCH_BYTES,
      CSR_SCISSOR_ENABLE,
      CSR_SCISSOR_LEFT,
      CSR_SCISSOR_TOP,
      CSR_SCISSOR_WIDTH,
      CSR_SCISSOR_HEIGHT
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [SCREEN_BITS-1:0]         screen_width;
      logic [SCREEN_BITS-1:0]         screen_height;
      logic [PITCH_BITS-1:0]          pitch_bytes;
      logic                           scissor_enable;
      logic signed [SCISSOR_BITS-1:0] scissor_left;
      logic signed [SCISSOR_BITS-1:0] scissor_top;
      logic [SCISSOR_BITS-1:0]        scissor_width;
      logic [SCISSOR_BITS-1:0]        scissor_height;
   } cfg_type;

   typedef struct packed {
      logic                  op_code;
      coord_type             x_from;
      coord_type             y_from;
      coord_type             x_to;
      coord_type             y_to;
      logic [COLOR_BITS-1:0] color_in;
   } req_type;

   // Pixel leaving the stepping stage, before clipping.
   typedef struct packed {
      logic                  dead;
      logic                  done;
      coord_type             x;
      coord_type             y;
      logic [COLOR_BITS-1:0] color;
   } pix_type;

   typedef struct packed {
      logic                  write_enable;
      coord_type             pixel_x;
      coord_type             pixel_y;
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  line_done;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/clipped_line_rasterizer.sv =====
// Clipped line rasterizer, top level. Uses clr_pkg, clr_csr, clr_stepper, clr_clip.
// An accepted word is held in the stage-one register, then moves into the result
// register once that register is free.
// Throughput: one word per cycle unless the consumer stalls, start or step alike.
// Synchronous active-high reset empties both stages, drops any active line and
// clears every configuration register to zero.
`default_nettype none

module clipped_line_rasterizer import clr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op_code,
   input  logic signed [COORD_BITS-1:0] req_x_from,
   input  logic signed [COORD_BITS-1:0] req_y_from,
   input  logic signed [COORD_BITS-1:0] req_x_to,
   input  logic signed [COORD_BITS-1:0] req_y_to,
   input  logic [COLOR_BITS-1:0]    req_color_in,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_write_enable,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic [ADDR_BITS-1:0]     rsp_pixel_address,
   output logic [COLOR_BITS-1:0]    rsp_pixel_color,
   output logic                     rsp_line_done,

   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // The block is a two-stage pipeline. Stage one holds the line state, sets
   // up a line on a start word or takes one Bresenham step per step word,
   // leaving the unclipped pixel in its stage register. Stage two clips that
   // pixel against the screen and the scissor box, forms the word address
   // with one small multiply, and holds the result word until the consumer takes it.

   cfg_type cfg;
   req_type req;
   pix_type pix;
   rsp_type rsp;
   logic    pix_valid;
   logic    s1_ready;
   logic    s2_ready;
   logic    load;

   // The result register frees up when it is empty or being taken this
   // cycle; stage one moves whenever stage two can take its word. A stall
   // reaches the producer only when both stages are full.
   assign s2_ready  = !rsp_valid || !rsp_stall;
   assign s1_ready  = !pix_valid || s2_ready;
   assign req_stall = !s1_ready;
   assign load      = req_valid && s1_ready;

   assign req.op_code  = req_op_code;
   assign req.x_from   = req_x_from;
   assign req.y_from   = req_y_from;
   assign req.x_to     = req_x_to;
   assign req.y_to     = req_y_to;
   assign req.color_in = req_color_in;

   // Configuration writes are to be made only while the pipeline is idle; the block
   // does not enforce this, and the clipping stage reads the registers directly.
   clr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   clr_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .advance   (s1_ready),
      .req       (req),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   clr_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .advance   (s2_ready),
      .pix_valid (pix_valid),
      .pix       (pix),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_write_enable  = rsp.write_enable;
   assign rsp_pixel_x       = rsp.pixel_x;
   assign rsp_pixel_y       = rsp.pixel_y;
   assign rsp_pixel_address = rsp.pixel_address;
   assign rsp_pixel_color   = rsp.pixel_color;
   assign rsp_line_done     = rsp.line_done;

endmodule

`default_nettype wire

// ===== sv/clr_csr.sv =====
// Configuration registers of the clipped line rasterizer.
// Depends on clr_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module clr_csr import clr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:   cfg_in.screen_width   = csr_wdata[SCREEN_BITS-1:0];
            CSR_SCREEN_HEIGHT:  cfg_in.screen_height  = csr_wdata[SCREEN_BITS-1:0];
            CSR_PITCH_BYTES:    cfg_in.pitch_bytes    = csr_wdata[PITCH_BITS-1:0];
            CSR_SCISSOR_ENABLE: cfg_in.scissor_enable = csr_wdata[0];
            CSR_SCISSOR_LEFT:   cfg_in.scissor_left   = signed'(csr_wdata[SCISSOR_BITS-1:0]);
            CSR_SCISSOR_TOP:    cfg_in.scissor_top    = signed'(csr_wdata[SCISSOR_BITS-1:0]);
            CSR_SCISSOR_WIDTH:  cfg_in.scissor_width  = csr_wdata[SCISSOR_BITS-1:0];
            CSR_SCISSOR_HEIGHT: cfg_in.scissor_height = csr_wdata[SCISSOR_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/clr_stepper.sv =====
// Line state and Bresenham step of the clipped line rasterizer, with the
// stage register that holds the unclipped pixel. Depends on clr_pkg.
`default_nettype none

module clr_stepper import clr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    advance,
   input  req_type req,
   output logic    pix_valid,
   output pix_type pix
);

   coord_type                    cur_x_ff, cur_y_ff, target_x_ff, target_y_ff;
   coord_type                    cur_x_in, cur_y_in, target_x_in, target_y_in;
   logic [COORD_BITS-1:0]        abs_dx_ff, abs_dy_ff, abs_dx_in, abs_dy_in;
   logic                         step_x_neg_ff, step_y_neg_ff, step_x_neg_in, step_y_neg_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         active_ff, active_in;
   logic                         valid_ff;
   pix_type                      pix_ff, pix_in;

   logic signed [DIFF_BITS-1:0]  dx, dy, mag_x, mag_y;
   logic                         neg_x, neg_y;
   logic [COORD_BITS-1:0]        adx, ady;
   logic signed [ERR_BITS-1:0]   half_x, half_y, adx_e, ady_e;
   logic                         move_x, move_y;
   coord_type                    dir_x, dir_y, next_x, next_y;
   logic                         start_done, step_done;

   always_comb begin
      // Setup for a new line.
      dx     = DIFF_BITS'(req.x_to) - DIFF_BITS'(req.x_from);
      dy     = DIFF_BITS'(req.y_to) - DIFF_BITS'(req.y_from);
      neg_x  = !(dx > 0);
      neg_y  = !(dy > 0);
      mag_x  = neg_x ? -dx : dx;
      mag_y  = neg_y ? -dy : dy;
      adx    = mag_x[COORD_BITS-1:0];
      ady    = mag_y[COORD_BITS-1:0];
      // Halving toward zero: shift the magnitude, then apply the sign.
      half_x = signed'(ERR_BITS'(adx >> 1));
      half_y = signed'(ERR_BITS'(ady >> 1));
      start_done = (req.x_from == req.x_to) && (req.y_from == req.y_to);

      // One step of the active line; both tests look at the old error.
      adx_e  = signed'(ERR_BITS'(abs_dx_ff));
      ady_e  = signed'(ERR_BITS'(abs_dy_ff));
      move_x = error_ff > -adx_e;
      move_y = error_ff < ady_e;
      dir_x  = step_x_neg_ff ? coord_type'(-1) : coord_type'(1);
      dir_y  = step_y_neg_ff ? coord_type'(-1) : coord_type'(1);
      next_x = move_x ? cur_x_ff + dir_x : cur_x_ff;
      next_y = move_y ? cur_y_ff + dir_y : cur_y_ff;
      step_done = (next_x == target_x_ff) && (next_y == target_y_ff);

      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      abs_dx_in     = abs_dx_ff;
      abs_dy_in     = abs_dy_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_in      = error_ff;
      color_in      = color_ff;
      active_in     = active_ff;
      pix_in        = '0;

      if (req.op_code == OP_START) begin
         cur_x_in      = req.x_from;
         cur_y_in      = req.y_from;
         target_x_in   = req.x_to;
         target_y_in   = req.y_to;
         abs_dx_in     = adx;
         abs_dy_in     = ady;
         step_x_neg_in = neg_x;
         step_y_neg_in = neg_y;
         error_in      = (adx > ady) ? half_x : -half_y;
         color_in      = req.color_in;
         active_in     = !start_done;
         pix_in.done   = start_done;
         pix_in.x      = req.x_from;
         pix_in.y      = req.y_from;
         pix_in.color  = req.color_in;
      end else if (active_ff) begin
         cur_x_in      = next_x;
         cur_y_in      = next_y;
         error_in      = error_ff - (move_x ? ady_e : '0) + (move_y ? adx_e : '0);
         active_in     = !step_done;
         pix_in.done   = step_done;
         pix_in.x      = next_x;
         pix_in.y      = next_y;
         pix_in.color  = color_ff;
      end else begin
         // Step with no line: a dead pixel that only reports done.
         pix_in.dead   = 1'b1;
         pix_in.done   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= load;
         end
         if (load) begin
            active_ff <= active_in;
         end
      end
      if (load) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         target_x_ff   <= target_x_in;
         target_y_ff   <= target_y_in;
         abs_dx_ff     <= abs_dx_in;
         abs_dy_ff     <= abs_dy_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         error_ff      <= error_in;
         color_ff      <= color_in;
         pix_ff        <= pix_in;
      end
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

endmodule

`default_nettype wire

// ===== sv/clr_clip.sv =====
// Screen and scissor clipping, word address and result register of the
// clipped line rasterizer. Depends on clr_pkg.
`default_nettype none

module clr_clip import clr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    pix_valid,
   input  pix_type pix,
   input  cfg_type cfg,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic signed [CLIP_BITS-1:0]          xs, ys, ws, hs, left_s, top_s, right_s, bottom_s;
   logic [DIM_BITS-1:0]                  w_sat, h_sat;
   logic                                 on_screen, in_box, we;
   logic [POS_BITS+STRIDE_BITS-1:0]      prod;
   logic [ADDR_BITS-1:0]                 addr_full;
   logic                                 valid_ff;
   rsp_type                              rsp_ff, rsp_in;

   always_comb begin
      xs       = CLIP_BITS'(pix.x);
      ys       = CLIP_BITS'(pix.y);
      w_sat    = (cfg.screen_width  > MAX_DIM) ? DIM_BITS'(MAX_DIM) : DIM_BITS'(cfg.screen_width);
      h_sat    = (cfg.screen_height > MAX_DIM) ? DIM_BITS'(MAX_DIM) : DIM_BITS'(cfg.screen_height);
      ws       = signed'(CLIP_BITS'(w_sat));
      hs       = signed'(CLIP_BITS'(h_sat));
      on_screen = (xs >= 0) && (ys >= 0) && (xs < ws) && (ys < hs);

      left_s   = CLIP_BITS'(cfg.scissor_left);
      top_s    = CLIP_BITS'(cfg.scissor_top);
      right_s  = left_s + signed'(CLIP_BITS'(cfg.scissor_width));
      bottom_s = top_s  + signed'(CLIP_BITS'(cfg.scissor_height));
      in_box   = (xs >= left_s) && (xs < right_s) && (ys >= top_s) && (ys < bottom_s);

      we       = !pix.dead && on_screen && (!cfg.scissor_enable || in_box);

      // A written pixel lies below MAX_DIM in both axes. The sum wraps at the
      // address width.
      prod      = (POS_BITS+STRIDE_BITS)'(ys[POS_BITS-1:0])
                * (POS_BITS+STRIDE_BITS)'(cfg.pitch_bytes[PITCH_BITS-1:2]);
      addr_full = ADDR_BITS'(prod) + ADDR_BITS'(xs[POS_BITS-1:0]);

      rsp_in.write_enable  = we;
      rsp_in.pixel_x       = pix.x;
      rsp_in.pixel_y       = pix.y;
      rsp_in.pixel_address = we ? addr_full : '0;
      rsp_in.pixel_color   = pix.color;
      rsp_in.line_done     = pix.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= pix_valid;
      end
      if (advance && pix_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/clr_checker.sv =====
// Port-level assertions for the clipped line rasterizer, bound to the top level.
// Depends on clr_pkg and on the port list of clipped_line_rasterizer.
`default_nettype none

module clr_checker import clr_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     req_op_code,
   input logic signed [COORD_BITS-1:0] req_x_from,
   input logic signed [COORD_BITS-1:0] req_y_from,
   input logic signed [COORD_BITS-1:0] req_x_to,
   input logic signed [COORD_BITS-1:0] req_y_to,
   input logic [COLOR_BITS-1:0]    req_color_in,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_write_enable,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic [ADDR_BITS-1:0]     rsp_pixel_address,
   input logic [COLOR_BITS-1:0]    rsp_pixel_color,
   input logic                     rsp_line_done,
   input logic                     csr_write_enable,
   input logic [CSR_IDX_BITS-1:0]  csr_index,
   input logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_enable)
         && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_pixel_address) && $stable(rsp_pixel_color)
         && $stable(rsp_line_done))
      else $error("result word changed while stalled");

   // Every accepted word is followed by a valid result word at the output.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted word produced no result");

   // The input only stalls when the result register is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with the result register empty");

   // A clipped pixel carries a zero address.
   a_clip_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_pixel_address == '0)
      else $error("clipped pixel has a nonzero address");

   // A written pixel never has a negative coordinate.
   a_write_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> !rsp_pixel_x[COORD_BITS-1] && !rsp_pixel_y[COORD_BITS-1])
      else $error("written pixel has a negative coordinate");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (.*);

`default_nettype wire
